FILE: src/dll_pkg.sv
// ----------------------------------------------------------------------------
// Doubly linked list package
// Shared constants, operation codes, status codes and the node RAM write
// enables used by the list manager and its submodules.
// ----------------------------------------------------------------------------
package dll_pkg;

  // Default pool size and the longest run of results one operation emits.
  localparam int unsigned NodesDef   = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned ModeW      = 4;

  // Operation codes carried by the mode field of an input item.
  localparam logic [ModeW-1:0] MODE_INS_HEAD = 4'd0;
  localparam logic [ModeW-1:0] MODE_INS_TAIL = 4'd1;
  localparam logic [ModeW-1:0] MODE_INS_AFT  = 4'd2;
  localparam logic [ModeW-1:0] MODE_INS_BEF  = 4'd3;
  localparam logic [ModeW-1:0] MODE_DEL_HEAD = 4'd4;
  localparam logic [ModeW-1:0] MODE_DEL_TAIL = 4'd5;
  localparam logic [ModeW-1:0] MODE_DEL_AFT  = 4'd6;
  localparam logic [ModeW-1:0] MODE_DEL_BEF  = 4'd7;
  localparam logic [ModeW-1:0] MODE_CLEAR    = 4'd8;
  localparam logic [ModeW-1:0] MODE_READ     = 4'd9;

  // Status codes of a result item.
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_EMPTY         = 3'd1,
    ST_NOT_FOUND     = 3'd2,
    ST_WRONG_POS     = 3'd3,
    ST_FULL          = 3'd4,
    ST_ALREADY_EMPTY = 3'd5
  } status_e;

  // Write enables of the three node arrays.
  typedef struct packed {
    logic val_we;
    logic nxt_we;
    logic prv_we;
  } ram_we_t;

endpackage

FILE: src/dll_node_ram.sv
// ----------------------------------------------------------------------------
// Node RAM
// Value, next-link and prev-link arrays of the node pool. One shared read
// address with registered read data, one write port per array.
// ----------------------------------------------------------------------------
module dll_node_ram #(
  parameter int unsigned NODES = dll_pkg::NodesDef,
  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1,
  localparam int unsigned IW = $clog2(NODES + 1)
) (
  input  logic                           clk_i,
  input  logic [AW-1:0]                  raddr_i,
  input  dll_pkg::ram_we_t               we_i,
  input  logic [AW-1:0]                  val_addr_i,
  input  logic [dll_pkg::DataW-1:0]      val_data_i,
  input  logic [AW-1:0]                  nxt_addr_i,
  input  logic [IW-1:0]                  nxt_data_i,
  input  logic [AW-1:0]                  prv_addr_i,
  input  logic [IW-1:0]                  prv_data_i,
  output logic [dll_pkg::DataW-1:0]      rd_value_o,
  output logic [IW-1:0]                  rd_next_o,
  output logic [IW-1:0]                  rd_prev_o
);
  import dll_pkg::*;

  logic [DataW-1:0] value_mem [NODES];
  logic [IW-1:0]    next_mem  [NODES];
  logic [IW-1:0]    prev_mem  [NODES];

  // Writes, one per array and cycle.
  always_ff @(posedge clk_i) begin
    if (we_i.val_we) begin
      value_mem[val_addr_i] <= val_data_i;
    end
    if (we_i.nxt_we) begin
      next_mem[nxt_addr_i] <= nxt_data_i;
    end
    if (we_i.prv_we) begin
      prev_mem[prv_addr_i] <= prv_data_i;
    end
  end

  // Registered read of all three fields of one node.
  always_ff @(posedge clk_i) begin
    rd_value_o <= value_mem[raddr_i];
    rd_next_o  <= next_mem[raddr_i];
    rd_prev_o  <= prev_mem[raddr_i];
  end

endmodule

FILE: src/dll_free_map.sv
// ----------------------------------------------------------------------------
// Free map
// One flag per node slot, with lowest-free-slot selection for allocation,
// single-slot release and a clear that frees the whole pool.
// ----------------------------------------------------------------------------
module dll_free_map #(
  parameter int unsigned NODES = dll_pkg::NodesDef,
  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic          free_i,
  input  logic [AW-1:0] free_idx_i,
  input  logic          clear_all_i,
  output logic          full_o,
  output logic          all_free_o,
  output logic [AW-1:0] low_idx_o
);
  import dll_pkg::*;

  logic [NODES-1:0] free_q, free_d;

  // Priority encoder: the lowest free slot wins.
  always_comb begin
    low_idx_o = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        low_idx_o = AW'(i);
      end
    end
  end

  assign full_o     = ~|free_q;
  assign all_free_o = &free_q;

  // Next value of the map.
  always_comb begin
    free_d = free_q;
    if (take_i) begin
      free_d[low_idx_o] = 1'b0;
    end
    if (free_i) begin
      free_d[free_idx_i] = 1'b1;
    end
    if (clear_all_i) begin
      free_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else begin
      free_q <= free_d;
    end
  end

endmodule

FILE: src/doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager
// Bounded doubly linked list in a node pool, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Head/tail insert writes the node, then links it in; head/tail delete unlinks
// it; key based operations search node by node first. Read out and clear emit
// one item per cycle unless the output stalls, reading one node per cycle.
// Throughput: one item at a time; the node RAM read port sets the walk rate.
// Reset empties the list and frees all slots; node contents are not cleared.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager #(
  parameter int unsigned NODES = dll_pkg::NodesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dll_pkg::ModeW-1:0]        mode_i,
  input  logic signed [dll_pkg::DataW-1:0] value_i,
  input  logic signed [dll_pkg::DataW-1:0] key_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       status_o,
  output logic signed [dll_pkg::DataW-1:0] item_o,
  output logic                             last_o
);
  import dll_pkg::*;

  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned IW = $clog2(NODES + 1);
  localparam int unsigned CW = $clog2(MaxResults + 1);
  localparam logic [IW-1:0] Nil = IW'(NODES);
  localparam logic [CW-1:0] CntFinal = CW'(MaxResults - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SRCH   = 7'b0000010,
    S_UNLINK = 7'b0000100,
    S_INS_A  = 7'b0001000,
    S_INS_B  = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [DataW-1:0] value_q, value_d;
  logic [DataW-1:0] key_q, key_d;
  logic [IW-1:0]    cur_q, cur_d;
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    tail_q, tail_d;
  logic [IW-1:0]    px_q, px_d;
  logic [IW-1:0]    nx_q, nx_d;
  logic [AW-1:0]    x_q, x_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  status_e          res_status_q, res_status_d;
  logic [DataW-1:0] res_item_q, res_item_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [DataW-1:0] out_item_q, out_item_d;
  logic             out_last_q, out_last_d;

  // RAM and free map hookup.
  ram_we_t          ram_we;
  logic [AW-1:0]    val_addr, nxt_addr, prv_addr;
  logic [IW-1:0]    nxt_data, prv_data;
  logic [DataW-1:0] rd_value;
  logic [IW-1:0]    rd_next, rd_prev;
  logic             fm_take, fm_free, fm_clear, fm_full, fm_all_free;
  logic [AW-1:0]    fm_low;

  logic slot_free;
  logic in_acc;
  logic fin;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign fin        = (rd_next == Nil) || (cnt_q == CntFinal);

  dll_node_ram #(.NODES(NODES)) u_ram (
    .clk_i      (clk_i),
    .raddr_i    (cur_d[AW-1:0]),
    .we_i       (ram_we),
    .val_addr_i (val_addr),
    .val_data_i (value_q),
    .nxt_addr_i (nxt_addr),
    .nxt_data_i (nxt_data),
    .prv_addr_i (prv_addr),
    .prv_data_i (prv_data),
    .rd_value_o (rd_value),
    .rd_next_o  (rd_next),
    .rd_prev_o  (rd_prev)
  );

  dll_free_map #(.NODES(NODES)) u_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (fm_take),
    .free_i      (fm_free),
    .free_idx_i  (cur_q[AW-1:0]),
    .clear_all_i (fm_clear),
    .full_o      (fm_full),
    .all_free_o  (fm_all_free),
    .low_idx_o   (fm_low)
  );

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    value_d      = value_q;
    key_d        = key_q;
    cur_d        = cur_q;
    head_d       = head_q;
    tail_d       = tail_q;
    px_d         = px_q;
    nx_d         = nx_q;
    x_d          = x_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_item_d   = res_item_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_item_d   = out_item_q;
    out_last_d   = out_last_q;
    ram_we       = '0;
    val_addr     = x_q;
    nxt_addr     = px_q[AW-1:0];
    prv_addr     = nx_q[AW-1:0];
    nxt_data     = nx_q;
    prv_data     = px_q;
    fm_take      = 1'b0;
    fm_free      = 1'b0;
    fm_clear     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_d       = mode_i;
          value_d      = value_i;
          key_d        = key_i;
          res_item_d   = '0;
          cnt_d        = '0;
          cur_d        = head_q;
          // Dispatch on the operation.
          if (mode_i == MODE_INS_HEAD || mode_i == MODE_INS_TAIL) begin
            if (fm_full) begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end else begin
              px_d    = (mode_i == MODE_INS_HEAD) ? Nil : tail_q;
              nx_d    = (mode_i == MODE_INS_HEAD) ? head_q : Nil;
              state_d = S_INS_A;
            end
          end else if (mode_i == MODE_INS_AFT || mode_i == MODE_INS_BEF) begin
            if (fm_full) begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end else if (head_q == Nil) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_RESP;
            end else begin
              state_d = S_SRCH;
            end
          end else if (mode_i == MODE_DEL_HEAD || mode_i == MODE_DEL_TAIL ||
                       mode_i == MODE_DEL_AFT || mode_i == MODE_DEL_BEF) begin
            if (head_q == Nil) begin
              res_status_d = ST_EMPTY;
              state_d      = S_RESP;
            end else if (mode_i == MODE_DEL_HEAD) begin
              state_d = S_UNLINK;
            end else if (mode_i == MODE_DEL_TAIL) begin
              cur_d   = tail_q;
              state_d = S_UNLINK;
            end else begin
              state_d = S_SRCH;
            end
          end else if (mode_i == MODE_CLEAR || mode_i == MODE_READ) begin
            if (head_q == Nil) begin
              res_status_d = (mode_i == MODE_CLEAR) ? ST_ALREADY_EMPTY : ST_EMPTY;
              state_d      = S_RESP;
            end else begin
              state_d = S_WALK;
            end
          end
        end
      end

      // One node compared per cycle; the next read is issued from the link.
      S_SRCH: begin
        if (rd_value == key_q) begin
          if (mode_q == MODE_INS_AFT) begin
            px_d    = cur_q;
            nx_d    = rd_next;
            state_d = S_INS_A;
          end else if (mode_q == MODE_INS_BEF) begin
            px_d    = rd_prev;
            nx_d    = cur_q;
            state_d = S_INS_A;
          end else if (mode_q == MODE_DEL_AFT) begin
            if (rd_next == Nil) begin
              res_status_d = ST_WRONG_POS;
              state_d      = S_RESP;
            end else begin
              cur_d   = rd_next;
              state_d = S_UNLINK;
            end
          end else begin
            if (rd_prev == Nil || rd_prev == head_q) begin
              res_status_d = ST_WRONG_POS;
              state_d      = S_RESP;
            end else begin
              cur_d   = rd_prev;
              state_d = S_UNLINK;
            end
          end
        end else if (rd_next == Nil) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_RESP;
        end else begin
          cur_d = rd_next;
        end
      end

      // Node cur is read; splice it out of the list.
      S_UNLINK: begin
        if (mode_q == MODE_DEL_AFT && rd_next == Nil) begin
          res_status_d = ST_WRONG_POS;
          state_d      = S_RESP;
        end else begin
          nxt_addr = rd_prev[AW-1:0];
          nxt_data = rd_next;
          prv_addr = rd_next[AW-1:0];
          prv_data = rd_prev;
          if (rd_prev != Nil) begin
            ram_we.nxt_we = 1'b1;
          end else begin
            head_d = rd_next;
          end
          if (rd_next != Nil) begin
            ram_we.prv_we = 1'b1;
          end else begin
            tail_d = rd_prev;
          end
          fm_free      = 1'b1;
          res_status_d = ST_OK;
          res_item_d   = rd_value;
          state_d      = S_RESP;
        end
      end

      // Write the new node into the lowest free slot.
      S_INS_A: begin
        fm_take       = 1'b1;
        x_d           = fm_low;
        val_addr      = fm_low;
        nxt_addr      = fm_low;
        prv_addr      = fm_low;
        nxt_data      = nx_q;
        prv_data      = px_q;
        ram_we.val_we = 1'b1;
        ram_we.nxt_we = 1'b1;
        ram_we.prv_we = 1'b1;
        state_d       = S_INS_B;
      end

      // Point the neighbors, or head and tail, at the new node.
      S_INS_B: begin
        nxt_addr = px_q[AW-1:0];
        nxt_data = {{(IW-AW){1'b0}}, x_q};
        prv_addr = nx_q[AW-1:0];
        prv_data = {{(IW-AW){1'b0}}, x_q};
        if (px_q != Nil) begin
          ram_we.nxt_we = 1'b1;
        end else begin
          head_d = {{(IW-AW){1'b0}}, x_q};
        end
        if (nx_q != Nil) begin
          ram_we.prv_we = 1'b1;
        end else begin
          tail_d = {{(IW-AW){1'b0}}, x_q};
        end
        res_status_d = ST_OK;
        state_d      = S_RESP;
      end

      // Emit one list value per cycle from the head while the output slot is free.
      S_WALK: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_item_d   = rd_value;
          out_last_d   = fin;
          cnt_d        = cnt_q + 1'b1;
          if (fin) begin
            if (mode_q == MODE_CLEAR) begin
              head_d   = Nil;
              tail_d   = Nil;
              fm_clear = 1'b1;
            end
            state_d = S_IDLE;
          end else begin
            cur_d = rd_next;
          end
        end
      end

      // Single result of the operation.
      S_RESP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_item_d   = res_item_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= Nil;
      tail_q      <= Nil;
      cur_q       <= Nil;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    value_q      <= value_d;
    key_q        <= key_d;
    px_q         <= px_d;
    nx_q         <= nx_d;
    x_q          <= x_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_item_q   <= res_item_d;
    out_status_q <= out_status_d;
    out_item_q   <= out_item_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign item_o      = out_item_q;
  assign last_o      = out_last_q;

  // Head and tail are null together.
  a_head_tail_nil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == Nil) == (tail_q == Nil))
    else $error("head and tail disagree on an empty list");

  // An empty list owns no slot.
  a_empty_all_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && head_q == Nil) |-> fm_all_free)
    else $error("empty list with slots still taken");

  // Unlinking always works on a real node.
  a_unlink_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UNLINK) |-> (cur_q != Nil))
    else $error("unlink of a null node");

  // Allocation never starts on a full pool.
  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_A) |-> !fm_full)
    else $error("allocation from a full pool");

endmodule

FILE: sim/tb_doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager testbench
// Drives list operations through the valid/ready input channel and checks
// every result item against a behavioral model of the node pool. A directed
// table covers the edge cases, then a random phase exercises the list deeply.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_manager;
  import dll_pkg::*;

  localparam int unsigned NODES    = 16;
  localparam int unsigned NIL      = NODES;
  localparam int unsigned WDOG_MAX = 20000;

  // Mode codes past the last operation are ignored by the block.
  localparam logic [ModeW-1:0] MODE_BAD_LO = 4'd10;
  localparam logic [ModeW-1:0] MODE_BAD_HI = 4'd15;

  typedef struct packed {
    status_e     status;
    logic [31:0] item;
    logic        last;
  } list_result_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [31:0]      value;
    logic [31:0]      key;
    logic             typed;
    list_result_t     res;
  } op_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ModeW-1:0]    mode_i;
  logic signed [31:0]  value_i;
  logic signed [31:0]  key_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [2:0]          status_o;
  logic signed [31:0]  item_o;
  logic                last_o;

  // Model state of the node pool.
  logic [31:0] pool_val [NODES];
  int unsigned pool_nxt [NODES];
  int unsigned pool_prv [NODES];
  bit          pool_free [NODES];
  int unsigned head_q;
  int unsigned tail_q;

  list_result_t pending_results[$];
  list_result_t typed_results[$];
  int unsigned  errors;
  int unsigned  items_sent;
  int unsigned  results_seen;
  int unsigned  wdog;
  bit           calm;
  bit           hold_tx;

  doubly_linked_list_manager #(.NODES(NODES)) dut (.*);

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Search from the head for the first node holding the value.
  function automatic int unsigned search_key(logic [31:0] k);
    int unsigned cur;
    cur = head_q;
    for (int s = 0; s < NODES && cur < NODES; s++) begin
      if (pool_val[cur] == k) return cur;
      cur = pool_nxt[cur];
    end
    return NIL;
  endfunction

  function automatic logic [31:0] unlink(int unsigned x);
    int unsigned p;
    int unsigned n;
    p = pool_prv[x];
    n = pool_nxt[x];
    if (p < NODES) pool_nxt[p] = n; else head_q = n;
    if (n < NODES) pool_prv[n] = p; else tail_q = p;
    pool_free[x] = 1'b1;
    return pool_val[x];
  endfunction

  function automatic list_result_t mk(status_e s, logic [31:0] v);
    list_result_t r;
    r.status = s;
    r.item   = v;
    r.last   = 1'b1;
    return r;
  endfunction

  // Apply one operation to the model and queue the results it causes.
  function automatic void predict_list_op(logic [ModeW-1:0] m, logic [31:0] v,
                                          logic [31:0] k);
    int unsigned x;
    int unsigned y;
    int unsigned kn;
    int unsigned cur;
    int unsigned cnt;
    list_result_t r;
    if (m <= MODE_INS_BEF) begin
      x = NIL;
      for (int i = NODES - 1; i >= 0; i--) if (pool_free[i]) x = i;
      if (x == NIL) begin
        pending_results.push_back(mk(ST_FULL, 0));
        return;
      end
      kn = NIL;
      if (m == MODE_INS_AFT || m == MODE_INS_BEF) begin
        kn = search_key(k);
        if (kn == NIL) begin
          pending_results.push_back(mk(ST_NOT_FOUND, 0));
          return;
        end
      end
      pool_free[x] = 1'b0;
      pool_val[x]  = v;
      if (m == MODE_INS_HEAD || (m == MODE_INS_BEF && kn == head_q)) begin
        pool_prv[x] = NIL;
        pool_nxt[x] = head_q;
        if (head_q < NODES) pool_prv[head_q] = x; else tail_q = x;
        head_q = x;
      end else if (m == MODE_INS_TAIL || (m == MODE_INS_AFT && kn == tail_q)) begin
        pool_nxt[x] = NIL;
        pool_prv[x] = tail_q;
        if (tail_q < NODES) pool_nxt[tail_q] = x; else head_q = x;
        tail_q = x;
      end else if (m == MODE_INS_AFT) begin
        y = pool_nxt[kn];
        pool_nxt[x] = y;
        pool_prv[x] = kn;
        if (y < NODES) pool_prv[y] = x;
        pool_nxt[kn] = x;
      end else begin
        y = pool_prv[kn];
        pool_prv[x] = y;
        pool_nxt[x] = kn;
        if (y < NODES) pool_nxt[y] = x;
        pool_prv[kn] = x;
      end
      pending_results.push_back(mk(ST_OK, 0));
    end else if (m <= MODE_DEL_BEF) begin
      if (head_q >= NODES) begin
        pending_results.push_back(mk(ST_EMPTY, 0));
      end else if (m == MODE_DEL_HEAD) begin
        pending_results.push_back(mk(ST_OK, unlink(head_q)));
      end else if (m == MODE_DEL_TAIL) begin
        pending_results.push_back(mk(ST_OK, unlink(tail_q)));
      end else begin
        kn = search_key(k);
        if (kn == NIL) begin
          pending_results.push_back(mk(ST_NOT_FOUND, 0));
          return;
        end
        if (m == MODE_DEL_AFT) begin
          y = pool_nxt[kn];
          if (y >= NODES || pool_nxt[y] >= NODES) begin
            pending_results.push_back(mk(ST_WRONG_POS, 0));
            return;
          end
        end else begin
          y = pool_prv[kn];
          if (kn == head_q || y == head_q || y >= NODES) begin
            pending_results.push_back(mk(ST_WRONG_POS, 0));
            return;
          end
        end
        pending_results.push_back(mk(ST_OK, unlink(y)));
      end
    end else if (m == MODE_CLEAR || m == MODE_READ) begin
      if (head_q >= NODES) begin
        pending_results.push_back(mk((m == MODE_CLEAR) ? ST_ALREADY_EMPTY : ST_EMPTY, 0));
        return;
      end
      cur = head_q;
      cnt = 0;
      for (int s = 0; s < NODES && cur < NODES; s++) begin
        if (cnt < MaxResults) begin
          r.status = ST_OK;
          r.item   = pool_val[cur];
          r.last   = (pool_nxt[cur] >= NODES) || (cnt + 1 == MaxResults);
          pending_results.push_back(r);
          cnt++;
        end
        cur = pool_nxt[cur];
      end
      if (m == MODE_CLEAR) begin
        for (int i = 0; i < NODES; i++) pool_free[i] = 1'b1;
        head_q = NIL;
        tail_q = NIL;
      end
    end
  endfunction

  // Idle decision: a 26 in 100 chance per call, none during the calm stretch.
  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 26);
  endfunction

  // Send one item, holding valid until it is accepted. Valid is raised at a
  // falling edge after the previous item dropped it, after any random idles.
  task automatic send_op(logic [ModeW-1:0] m, logic [31:0] v, logic [31:0] k);
    @(negedge clk_i);
    while (idle_now()) @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    key_i      <= k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_list_op(m, v, k);
    items_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !idle_now();
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("doubly_linked_list_manager test failed");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected: status %0d item %0d",
                 status_o, item_o);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status_o);
            errors++;
          end
          if (item_o !== exp_r.item) begin
            $error("item: expected %0d, actual %0d", $signed(exp_r.item), item_o);
            errors++;
          end
          if (last_o !== exp_r.last) begin
            $error("last: expected %0d, actual %0d", exp_r.last, last_o);
            errors++;
          end
        end
        if (typed_results.size() != 0) begin
          exp_r = typed_results.pop_front();
          if (status_o !== exp_r.status || item_o !== exp_r.item || last_o !== exp_r.last) begin
            $error("typed result: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                   exp_r.status, $signed(exp_r.item), exp_r.last,
                   status_o, item_o, last_o);
            errors++;
          end
        end
      end
    end
  end

  // Random key: mostly a value present in the list, else noise.
  function automatic logic [31:0] pick_key();
    int unsigned cur;
    int unsigned n;
    int unsigned pick;
    n = 0;
    for (int i = 0; i < NODES; i++) if (!pool_free[i]) n++;
    if (n == 0 || $urandom_range(9) < 2) return $urandom_range(7);
    pick = $urandom_range(n - 1);
    cur = head_q;
    for (int s = 0; s < pick; s++) cur = pool_nxt[cur];
    return pool_val[cur];
  endfunction

  op_row_t dir_rows[$];

  function automatic op_row_t row(logic [ModeW-1:0] m, logic [31:0] v, logic [31:0] k,
                                  logic t, status_e s, logic [31:0] it);
    op_row_t r;
    r.mode  = m;
    r.value = v;
    r.key   = k;
    r.typed = t;
    r.res   = mk(s, it);
    return r;
  endfunction

  initial begin
    logic [ModeW-1:0] m;
    logic [31:0]      v;
    int unsigned      roll;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    mode_i      = MODE_INS_HEAD;
    value_i     = 0;
    key_i       = 0;
    errors = 0; items_sent = 0; results_seen = 0; wdog = 0;
    calm = 1'b0; hold_tx = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      pool_free[i] = 1'b1;
      pool_val[i] = 0; pool_nxt[i] = 0; pool_prv[i] = 0;
    end
    head_q = NIL;
    tail_q = NIL;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: empty-list cases, extremes, positions and key misses.
    dir_rows.push_back(row(MODE_READ,     0, 0, 1, ST_EMPTY, 0));
    dir_rows.push_back(row(MODE_CLEAR,    0, 0, 1, ST_ALREADY_EMPTY, 0));
    dir_rows.push_back(row(MODE_DEL_HEAD, 0, 0, 1, ST_EMPTY, 0));
    dir_rows.push_back(row(MODE_DEL_AFT,  0, 0, 1, ST_EMPTY, 0));
    dir_rows.push_back(row(MODE_INS_AFT,  5, 0, 1, ST_NOT_FOUND, 0));
    dir_rows.push_back(row(MODE_INS_TAIL, 32'h7fffffff, 0, 1, ST_OK, 0));
    dir_rows.push_back(row(MODE_INS_HEAD, 32'h80000000, 0, 1, ST_OK, 0));
    dir_rows.push_back(row(MODE_INS_AFT,  32'hffffffff, 32'h7fffffff, 1, ST_OK, 0));
    dir_rows.push_back(row(MODE_INS_BEF,  1, 32'h80000000, 1, ST_OK, 0));
    dir_rows.push_back(row(MODE_INS_BEF,  2, 32'hffffffff, 0, ST_OK, 0));
    dir_rows.push_back(row(MODE_INS_AFT,  3, 1, 0, ST_OK, 0));
    dir_rows.push_back(row(MODE_READ,     0, 0, 0, ST_OK, 0));
    dir_rows.push_back(row(MODE_DEL_AFT,  0, 2, 1, ST_WRONG_POS, 0));
    dir_rows.push_back(row(MODE_DEL_BEF,  0, 1, 1, ST_WRONG_POS, 0));
    dir_rows.push_back(row(MODE_DEL_BEF,  0, 3, 1, ST_WRONG_POS, 0));
    dir_rows.push_back(row(MODE_DEL_AFT,  0, 32'h12345678, 1, ST_NOT_FOUND, 0));
    dir_rows.push_back(row(MODE_DEL_AFT,  0, 1, 0, ST_OK, 0));
    dir_rows.push_back(row(MODE_DEL_BEF,  0, 32'h7fffffff, 0, ST_OK, 0));
    dir_rows.push_back(row(MODE_BAD_LO,   0, 0, 0, ST_OK, 0));
    dir_rows.push_back(row(MODE_BAD_HI,   0, 0, 0, ST_OK, 0));
    dir_rows.push_back(row(MODE_DEL_HEAD, 0, 0, 1, ST_OK, 1));
    dir_rows.push_back(row(MODE_DEL_TAIL, 0, 0, 1, ST_OK, 32'hffffffff));
    dir_rows.push_back(row(MODE_CLEAR,    0, 0, 0, ST_OK, 0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) typed_results.push_back(dir_rows[i].res);
      send_op(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].key);
      // Keep the typed queue aligned with multi-result operations.
      while (pending_results.size() != 0 || typed_results.size() != 0) @(negedge clk_i);
    end

    // Fill the pool to overflow, walking through the full status.
    for (int i = 0; i <= NODES; i++) send_op(MODE_INS_TAIL, $urandom, 0);
    send_op(MODE_INS_AFT, 0, 0);
    send_op(MODE_READ, 0, 0);
    send_op(MODE_CLEAR, 0, 0);

    // Random phase: mostly well-formed inserts and deletes.
    for (int n = 0; n < 370; n++) begin
      calm = (n >= 150 && n < 200);
      if (n == 260) begin
        // Let the block drain completely before continuing.
        while (pending_results.size() != 0) @(negedge clk_i);
      end
      roll = $urandom_range(99);
      if (roll < 40)      m = ModeW'($urandom_range(3));
      else if (roll < 80) m = MODE_DEL_HEAD + ModeW'($urandom_range(3));
      else if (roll < 88) m = MODE_READ;
      else if (roll < 94) m = MODE_CLEAR;
      else                m = ModeW'($urandom_range(15));
      v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
      send_op(m, v, pick_key());
    end
    calm = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Ran %0d list operations with %0d result items checked.",
             items_sent, results_seen);
    $display("Covered empty, full, position, key-miss and read-out/clear cases.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("doubly_linked_list_manager test passed");
    end else begin
      $display("doubly_linked_list_manager test failed");
    end
    $finish;
  end

endmodule
